FILE: rtl/core/tes_pkg.sv
// Shared constants for the text encoding sniffer: class codes and marker bytes.
package tes_pkg;

  typedef logic [2:0] enc_class_t;

  localparam enc_class_t CLASS_ASCII   = 3'd0;
  localparam enc_class_t CLASS_BINARY  = 3'd1;
  localparam enc_class_t CLASS_UTF8    = 3'd2;
  localparam enc_class_t CLASS_UTF16LE = 3'd3;
  localparam enc_class_t CLASS_UTF16BE = 3'd4;
  localparam enc_class_t CLASS_UTF32LE = 3'd5;
  localparam enc_class_t CLASS_UTF32BE = 3'd6;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_FE    = 8'hFE;
  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] BYTE_EF    = 8'hEF;
  localparam logic [7:0] BYTE_BB    = 8'hBB;
  localparam logic [7:0] BYTE_BF    = 8'hBF;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;

  // Length codes used by the scan and the verdict (bytes in the buffer, saturating at seven).
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;
  localparam logic [2:0] LEN_SIX   = 3'd6;
  localparam logic [2:0] LEN_SEVEN = 3'd7;

endpackage

FILE: rtl/core/text_encoding_sniffer_top.sv
// Text encoding sniffer: byte-order mark check and delayed UTF-8 scan over a buffer.
//
// Usage: a buffer is presented one word (data_byte) per handshake on the input
// channel (in_valid / in_stall), with last_byte high on its final word. One
// encoding_class word is produced on the output channel (out_valid / out_stall)
// for each buffer, and only on its final word; all scanning state is then
// cleared so the very next input word opens a new buffer.
// The class passes from the snapshot register to the output register before it
// appears on out_valid. Throughput: one input word every cycle while in_stall is
// low, set by the window compare and counter update; buffers may follow each other
// back to back, even one word long.
// When the receiver stalls, the result is held in the output register and the
// finished buffer's totals wait in a snapshot register, so the input channel
// keeps taking words; in_stall rises only when both are full.
// Reset (rst, synchronous, active high) empties both registers and clears the
// head bytes, the delay window, the byte count and all counters.
// Counters are COUNT_WIDTH bits wide and saturate at all ones.
module text_encoding_sniffer_top
  import tes_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] encoding_class
);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t CountMax = '1;

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == CountMax) ? c : c + count_t'(1);
  endfunction

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    sat_add = sum[COUNT_WIDTH] ? CountMax : sum[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b[7:6] == 2'b10);
  endfunction

  // Working state of the buffer in progress.
  logic [7:0] head_bytes [4];
  logic [7:0] delay_window [6];
  logic [2:0] bytes_seen;
  logic [1:0] skip_remaining;
  count_t     high_bit_count, control_count;
  count_t     two_byte_count, three_byte_count, four_byte_count;

  // Snapshot of a finished buffer, waiting for the verdict stage.
  logic       snap_valid;
  logic [7:0] snap_head [4];
  logic [2:0] snap_len;
  count_t     snap_high, snap_control, snap_two, snap_three, snap_four;

  logic in_accept, snap_move;

  assign snap_move = !out_valid || !out_stall;
  assign in_stall  = snap_valid && !snap_move;
  assign in_accept = in_valid && !in_stall;

  // Scan of the oldest byte in the window, once six bytes are held.
  logic [7:0] scan_byte;
  logic       scan_on, scan_live;
  logic       hit_high, hit_control, hit_two, hit_three, hit_four;
  logic [1:0] skip_remaining_next;
  count_t     high_bit_count_next, control_count_next;
  count_t     two_byte_count_next, three_byte_count_next, four_byte_count_next;
  logic [7:0] head_next [4];
  logic [2:0] len_next;

  always_comb begin
    scan_byte = delay_window[0];
    scan_on   = (bytes_seen >= LEN_SIX);
    scan_live = scan_on && (skip_remaining == 2'd0);

    hit_high    = scan_live && scan_byte[7];
    hit_control = scan_live && !scan_byte[7] &&
                  ((scan_byte < BYTE_SPACE) || (scan_byte == BYTE_DEL)) &&
                  (scan_byte != BYTE_CR) && (scan_byte != BYTE_LF) &&
                  (scan_byte != BYTE_TAB);
    hit_two   = scan_live && (scan_byte[7:5] == 3'b110) && is_cont(delay_window[1]);
    hit_three = scan_live && (scan_byte[7:4] == 4'b1110) &&
                is_cont(delay_window[1]) && is_cont(delay_window[2]);
    hit_four  = scan_live && (scan_byte[7:3] == 5'b11110) &&
                is_cont(delay_window[1]) && is_cont(delay_window[2]) &&
                is_cont(delay_window[3]);

    skip_remaining_next = skip_remaining;
    if (scan_on) begin
      if (skip_remaining != 2'd0) begin
        skip_remaining_next = skip_remaining - 2'd1;
      end else if (hit_two) begin
        skip_remaining_next = 2'd1;
      end else if (hit_three) begin
        skip_remaining_next = 2'd2;
      end else if (hit_four) begin
        skip_remaining_next = 2'd3;
      end
    end

    high_bit_count_next   = hit_high    ? sat_inc(high_bit_count)   : high_bit_count;
    control_count_next    = hit_control ? sat_inc(control_count)    : control_count;
    two_byte_count_next   = hit_two     ? sat_inc(two_byte_count)   : two_byte_count;
    three_byte_count_next = hit_three   ? sat_inc(three_byte_count) : three_byte_count;
    four_byte_count_next  = hit_four    ? sat_inc(four_byte_count)  : four_byte_count;

    for (int i = 0; i < 4; i++) begin
      head_next[i] = head_bytes[i];
    end
    if (!bytes_seen[2]) begin
      head_next[bytes_seen[1:0]] = data_byte;
    end

    len_next = (bytes_seen == LEN_SEVEN) ? LEN_SEVEN : bytes_seen + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen       <= '0;
      skip_remaining   <= '0;
      high_bit_count   <= '0;
      control_count    <= '0;
      two_byte_count   <= '0;
      three_byte_count <= '0;
      four_byte_count  <= '0;
      for (int i = 0; i < 4; i++) begin
        head_bytes[i] <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        delay_window[i] <= '0;
      end
    end else if (in_accept) begin
      if (last_byte) begin
        // The buffer is complete: everything returns to its reset value.
        bytes_seen       <= '0;
        skip_remaining   <= '0;
        high_bit_count   <= '0;
        control_count    <= '0;
        two_byte_count   <= '0;
        three_byte_count <= '0;
        four_byte_count  <= '0;
        for (int i = 0; i < 4; i++) begin
          head_bytes[i] <= '0;
        end
        for (int i = 0; i < 6; i++) begin
          delay_window[i] <= '0;
        end
      end else begin
        bytes_seen       <= len_next;
        skip_remaining   <= skip_remaining_next;
        high_bit_count   <= high_bit_count_next;
        control_count    <= control_count_next;
        two_byte_count   <= two_byte_count_next;
        three_byte_count <= three_byte_count_next;
        four_byte_count  <= four_byte_count_next;
        for (int i = 0; i < 4; i++) begin
          head_bytes[i] <= head_next[i];
        end
        for (int i = 0; i < 5; i++) begin
          delay_window[i] <= delay_window[i+1];
        end
        delay_window[5] <= data_byte;
      end
    end
  end

  // Snapshot register: takes the totals of a buffer on its final word.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_move) begin
      snap_valid <= 1'b0;
    end
    if (in_accept && last_byte) begin
      snap_len     <= len_next;
      snap_high    <= high_bit_count_next;
      snap_control <= control_count_next;
      snap_two     <= two_byte_count_next;
      snap_three   <= three_byte_count_next;
      snap_four    <= four_byte_count_next;
      for (int i = 0; i < 4; i++) begin
        snap_head[i] <= head_next[i];
      end
    end
  end

  // Verdict from the snapshot: length and head bytes (marks) first, then scan totals.
  enc_class_t verdict;
  count_t     seq_total;
  logic       tail_zero;

  always_comb begin
    seq_total = sat_add(sat_add(snap_two, snap_three), snap_four);
    tail_zero = (snap_len >= LEN_FOUR) && (snap_head[2] == BYTE_ZERO) &&
                (snap_head[3] == BYTE_ZERO);
    if (snap_len < LEN_TWO) begin
      verdict = CLASS_ASCII;
    end else if ((snap_head[0] == BYTE_FE) && (snap_head[1] == BYTE_FF)) begin
      verdict = tail_zero ? CLASS_UTF32BE : CLASS_UTF16BE;
    end else if ((snap_head[0] == BYTE_FF) && (snap_head[1] == BYTE_FE)) begin
      verdict = tail_zero ? CLASS_UTF32LE : CLASS_UTF16LE;
    end else if ((snap_head[0] == BYTE_ZERO) && (snap_head[1] == BYTE_ZERO)) begin
      verdict = ((snap_len >= LEN_FOUR) && (snap_head[2] == BYTE_FE) &&
                 (snap_head[3] == BYTE_FF)) ? CLASS_UTF32BE : CLASS_BINARY;
    end else if (snap_head[0] == BYTE_EF) begin
      verdict = ((snap_len >= LEN_THREE) && (snap_head[1] == BYTE_BB) &&
                 (snap_head[2] == BYTE_BF)) ? CLASS_UTF8 : CLASS_BINARY;
    end else if ((seq_total != '0) && (seq_total >= snap_high) &&
                 (snap_control == '0)) begin
      verdict = CLASS_UTF8;
    end else if ((snap_control != '0) || (snap_high != '0)) begin
      verdict = CLASS_BINARY;
    end else begin
      verdict = CLASS_ASCII;
    end
  end

  // Output register: loads whenever it is empty or its word is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_move) begin
      out_valid <= snap_valid;
    end
    if (snap_move && snap_valid) begin
      encoding_class <= verdict;
    end
  end

endmodule
